FILE: rtl/core/rps_pkg.sv
// ----------------------------------------------------------------------------
// rps_pkg
// Shared types and constants of the rainbow phase scroller: operation codes,
// register indexes, field widths and the command word passed front to back.
// ----------------------------------------------------------------------------
package rps_pkg;

    // Field widths
    localparam int COORD_W  = 4;
    localparam int INDEX_W  = 8;
    localparam int PHASE_W  = 11;
    localparam int COLOR_W  = 8;
    localparam int SPEED_W  = 6;
    localparam int ZOOM_W   = 8;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;

    // Hue wheel: six segments of 256 steps
    localparam int WHEEL_LEN   = 1536;
    localparam int STORE_DEPTH = 256;
    localparam int COLOR_MAX   = 255;

    // Default configuration
    localparam int DEF_MATRIX_WIDTH = 16;
    localparam int DEF_QUEUE_DEPTH  = 4;
    localparam int SPEED_RESET      = 1;
    localparam int ZOOM_RESET       = 1;

    typedef enum logic {
        OP_ADVANCE = 1'b0,
        OP_RELOAD  = 1'b1
    } t_op;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SPEED = 2'd0,
        CFG_ZOOM  = 2'd1
    } t_cfg_idx;

    // Command word between front and back
    typedef struct packed {
        t_op                op;
        logic [INDEX_W-1:0] idx;
        logic [PHASE_W-1:0] phase;
    } t_cmd;

endpackage

FILE: rtl/core/rps_front.sv
// ----------------------------------------------------------------------------
// rps_front
// Accepts input words, computes the linear pixel index and, for reloads, the
// row phase (y * zoom) mod 1536, and pushes a command into the queue.
// ----------------------------------------------------------------------------
module rps_front
    import rps_pkg::*;
#(
    parameter int MATRIX_WIDTH = DEF_MATRIX_WIDTH
) (
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic               i_operation,
    input  logic [COORD_W-1:0] i_pixel_x,
    input  logic [COORD_W-1:0] i_pixel_y,
    input  logic [ZOOM_W-1:0]  i_zoom,
    input  logic               i_queue_full,
    output logic               o_push,
    output t_cmd               o_cmd
);

    localparam int MUL_W = COORD_W + ZOOM_W;
    localparam int POS_W = COORD_W + 8;

    logic [POS_W-1:0] row_base;
    logic [MUL_W-1:0] row_prod;
    logic [MUL_W-1:0] row_phase;

    // Accept whenever the queue has room
    assign o_in_ready = !i_queue_full;
    assign o_push     = i_in_valid && !i_queue_full;

    // Linear index wraps at the store depth
    assign row_base = POS_W'(i_pixel_y) * POS_W'(MATRIX_WIDTH);

    // Row phase: product stays below three wheel lengths
    assign row_prod = MUL_W'(i_pixel_y) * MUL_W'(i_zoom);

    always_comb begin
        if (row_prod >= MUL_W'(2 * WHEEL_LEN)) begin
            row_phase = row_prod - MUL_W'(2 * WHEEL_LEN);
        end else if (row_prod >= MUL_W'(WHEEL_LEN)) begin
            row_phase = row_prod - MUL_W'(WHEEL_LEN);
        end else begin
            row_phase = row_prod;
        end
    end

    // Build the command word
    always_comb begin
        o_cmd.op  = t_op'(i_operation);
        o_cmd.idx = INDEX_W'(row_base + POS_W'(i_pixel_x));
        if (o_cmd.op == OP_RELOAD) begin
            o_cmd.phase = PHASE_W'(row_phase);
        end else begin
            o_cmd.phase = '0;
        end
    end

endmodule

FILE: rtl/core/rps_queue.sv
// ----------------------------------------------------------------------------
// rps_queue
// Small register queue of command words between front and back, so that
// either side can stall without stopping the other.
// ----------------------------------------------------------------------------
module rps_queue
    import rps_pkg::*;
#(
    parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_push_cmd,
    output logic o_full,
    output logic o_valid,
    output t_cmd o_cmd,
    input  logic i_pop
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    t_cmd             r_slot [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;

    assign o_full  = (r_count == CNT_W'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_cmd   = r_slot[r_rd_ptr];

    // Advance pointers and fill count
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Store pushed words
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_push_cmd;
        end
    end

endmodule

FILE: rtl/core/rps_back.sv
// ----------------------------------------------------------------------------
// rps_back
// Executes commands against the phase memory: read on pop, modify and write
// back on retire, with a bypass for back-to-back hits on one pixel.
// Advances load the output register; color comes from the hue wheel.
// ----------------------------------------------------------------------------
module rps_back
    import rps_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic [SPEED_W-1:0] i_speed,
    input  logic               i_cmd_valid,
    input  t_cmd               i_cmd,
    output logic               o_cmd_pop,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic [INDEX_W-1:0] o_pixel_index,
    output logic [COLOR_W-1:0] o_red,
    output logic [COLOR_W-1:0] o_green,
    output logic [COLOR_W-1:0] o_blue
);

    localparam int SUM_W = PHASE_W + 1;

    function automatic logic [3*COLOR_W-1:0] hue_color(input logic [PHASE_W-1:0] phase);
        logic [COLOR_W-1:0] s;
        logic [COLOR_W-1:0] inv;
        logic [COLOR_W-1:0] full;
        logic [3*COLOR_W-1:0] rgb;
        s    = phase[COLOR_W-1:0];
        full = COLOR_W'(COLOR_MAX);
        inv  = full - s;
        unique case (phase[PHASE_W-1:COLOR_W])
            3'd0:    rgb = {full, s, 8'd0};
            3'd1:    rgb = {inv, full, 8'd0};
            3'd2:    rgb = {8'd0, full, s};
            3'd3:    rgb = {8'd0, inv, full};
            3'd4:    rgb = {s, 8'd0, full};
            default: rgb = {full, 8'd0, inv};
        endcase
        return rgb;
    endfunction

    logic [PHASE_W-1:0] r_mem [STORE_DEPTH];
    logic [PHASE_W-1:0] r_rd_phase;
    logic               r_fwd;
    logic [PHASE_W-1:0] r_fwd_phase;
    logic               r_s1_valid;
    t_cmd               r_s1_cmd;
    logic               r_out_valid;
    logic [INDEX_W-1:0] r_out_idx;
    logic [PHASE_W-1:0] r_out_phase;

    logic               out_free;
    logic               s1_retire;
    logic               s1_go;
    logic               s1_emit;
    logic [PHASE_W-1:0] old_phase;
    logic [SUM_W-1:0]   sum;
    logic [SUM_W-1:0]   wrapped;
    logic [PHASE_W-1:0] new_phase;
    logic [3*COLOR_W-1:0] rgb;

    // Stage handshake
    assign out_free  = !r_out_valid || i_out_ready;
    assign s1_emit   = r_s1_valid && (r_s1_cmd.op == OP_ADVANCE) && out_free;
    assign s1_retire = r_s1_valid && ((r_s1_cmd.op == OP_RELOAD) || out_free);
    assign s1_go     = !r_s1_valid || s1_retire;
    assign o_cmd_pop = i_cmd_valid && s1_go;

    // Modify: add speed and wrap once at the wheel length
    assign old_phase = r_fwd ? r_fwd_phase : r_rd_phase;
    assign sum       = SUM_W'(old_phase) + SUM_W'(i_speed);
    assign wrapped   = (sum >= SUM_W'(WHEEL_LEN)) ? sum - SUM_W'(WHEEL_LEN) : sum;
    assign new_phase = (r_s1_cmd.op == OP_RELOAD) ? r_s1_cmd.phase : PHASE_W'(wrapped);

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (s1_go) begin
                r_s1_valid <= o_cmd_pop;
            end
            if (s1_emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Phase memory: write back on retire, read on pop, bypass same-pixel hits
    always_ff @(posedge i_clk) begin
        if (s1_retire) begin
            r_mem[r_s1_cmd.idx] <= new_phase;
        end
        if (o_cmd_pop) begin
            r_rd_phase  <= r_mem[i_cmd.idx];
            r_s1_cmd    <= i_cmd;
            r_fwd       <= s1_retire && (r_s1_cmd.idx == i_cmd.idx);
            r_fwd_phase <= new_phase;
        end
    end

    // Output register payload
    always_ff @(posedge i_clk) begin
        if (s1_emit) begin
            r_out_idx   <= r_s1_cmd.idx;
            r_out_phase <= new_phase;
        end
    end

    assign rgb           = hue_color(r_out_phase);
    assign o_out_valid   = r_out_valid;
    assign o_pixel_index = r_out_idx;
    assign o_red         = rgb[3*COLOR_W-1:2*COLOR_W];
    assign o_green       = rgb[2*COLOR_W-1:COLOR_W];
    assign o_blue        = rgb[COLOR_W-1:0];

endmodule

FILE: rtl/core/rainbow_phase_scroll_top.sv
// ----------------------------------------------------------------------------
// rainbow_phase_scroll_top
// Per-pixel hue phase scroller for an LED matrix with a six-segment wheel.
// ----------------------------------------------------------------------------
// Input channel (i_in_valid / o_in_ready) takes one word per pixel: operation
// 0 advances the pixel phase by speed and emits its color, operation 1
// reloads the phase to (y * zoom) mod 1536 and emits nothing. Every pixel
// must be reloaded before its first advance.
// Output channel (o_out_valid / i_out_ready) carries pixel index and RGB.
// Configuration channel (i_cfg_valid / o_cfg_ready) writes speed (index 0)
// or zoom (index 1); it is always ready and other indexes are ignored.
// Throughput: one word per cycle while the output is not stalled, set by the
// pipelined read-modify-write of the phase memory (read on pop, write back
// on retire from stage 1 through a separate write port, with a bypass for
// the same pixel back to back). An advance word passes the command queue,
// stage 1 and the output register. A stalled receiver holds the output
// register; the command queue of QUEUE_DEPTH words keeps accepting until
// full, then o_in_ready drops. Reset clears the queue, pipeline and output
// valid, and sets speed and zoom to 1; the phase memory is not cleared.
// ----------------------------------------------------------------------------
module rainbow_phase_scroll_top
    import rps_pkg::*;
#(
    parameter int MATRIX_WIDTH = DEF_MATRIX_WIDTH,
    parameter int QUEUE_DEPTH  = DEF_QUEUE_DEPTH
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic                  i_operation,
    input  logic [COORD_W-1:0]    i_pixel_x,
    input  logic [COORD_W-1:0]    i_pixel_y,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic [INDEX_W-1:0]    o_pixel_index,
    output logic [COLOR_W-1:0]    o_red,
    output logic [COLOR_W-1:0]    o_green,
    output logic [COLOR_W-1:0]    o_blue,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    logic [SPEED_W-1:0] r_speed;
    logic [ZOOM_W-1:0]  r_zoom;

    logic queue_full;
    logic push;
    t_cmd push_cmd;
    logic queue_valid;
    t_cmd queue_cmd;
    logic pop;

    // Configuration registers
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_speed <= SPEED_W'(SPEED_RESET);
            r_zoom  <= ZOOM_W'(ZOOM_RESET);
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_SPEED: r_speed <= i_cfg_data[SPEED_W-1:0];
                CFG_ZOOM:  r_zoom  <= i_cfg_data[ZOOM_W-1:0];
                default:   ;
            endcase
        end
    end

    rps_front #(
        .MATRIX_WIDTH (MATRIX_WIDTH)
    ) u_front (
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_operation  (i_operation),
        .i_pixel_x    (i_pixel_x),
        .i_pixel_y    (i_pixel_y),
        .i_zoom       (r_zoom),
        .i_queue_full (queue_full),
        .o_push       (push),
        .o_cmd        (push_cmd)
    );

    rps_queue #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_push_cmd (push_cmd),
        .o_full     (queue_full),
        .o_valid    (queue_valid),
        .o_cmd      (queue_cmd),
        .i_pop      (pop)
    );

    rps_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_speed       (r_speed),
        .i_cmd_valid   (queue_valid),
        .i_cmd         (queue_cmd),
        .o_cmd_pop     (pop),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_pixel_index (o_pixel_index),
        .o_red         (o_red),
        .o_green       (o_green),
        .o_blue        (o_blue)
    );

endmodule
